[sv/voltage_dip_pattern_detector_unit_defines.svh]
// assertion macros shared by the checker
`ifndef VOLTAGE_DIP_PATTERN_DETECTOR_UNIT_DEFINES_SVH
`define VOLTAGE_DIP_PATTERN_DETECTOR_UNIT_DEFINES_SVH

// clocked assertion, off while reset is low
`define VDPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define VDPD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/vdpd_pkg.sv]
`default_nettype none

package vdpd_pkg;

    localparam int FIELD_W   = 10;
    localparam int PSEL_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_DEPTH   = 2'd2;

    localparam logic [PSEL_W-1:0] PSEL_PORT2 = 3'd2;
    localparam logic [PSEL_W-1:0] PSEL_PORT3 = 3'd3;
    localparam logic [PSEL_W-1:0] PSEL_PORT4 = 3'd4;

    localparam logic [PSEL_W-1:0]  RST_PORT_SELECT = 3'd1;
    localparam logic [FIELD_W-1:0] RST_PLATEAU_TOL = 10'd10;
    localparam logic [FIELD_W-1:0] RST_DIP_DEPTH   = 10'd30;

    localparam int MIN_SET_LEN = 6;

    typedef struct packed {
        logic in_rdy;
        logic hzero;
        logic hscan;
        logic pscan;
        logic dscan;
        logic addr_clr;
        logic addr_inc;
        logic scan_init;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic h_last;
        logic s_last;
        logic short_set;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[sv/vdpd_ctrl.sv]
`default_nettype none

module vdpd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_last_sample,
    input  wire vdpd_pkg::t_sts i_sts,
    output vdpd_pkg::t_cmd     o_cmd
);
    import vdpd_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_HSCAN = 3'd3;
    localparam logic [2:0] S_PSCAN = 3'd4;
    localparam logic [2:0] S_DSCAN = 3'd5;
    localparam logic [2:0] S_DTAIL = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.hzero    = 1'b1;
                w_cmd.addr_inc = 1'b1;
                if (i_sts.h_last) begin
                    w_cmd.addr_clr = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            S_LOAD: begin
                w_cmd.in_rdy = 1'b1;
                if (i_in_valid && i_last_sample) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                w_cmd.scan_init = 1'b1;
                n_state         = S_HSCAN;
            end
            S_HSCAN: begin
                w_cmd.hzero    = 1'b1;
                w_cmd.hscan    = 1'b1;
                w_cmd.addr_inc = 1'b1;
                if (i_sts.h_last) begin
                    w_cmd.addr_clr = 1'b1;
                    n_state        = S_PSCAN;
                end
            end
            S_PSCAN: begin
                w_cmd.pscan    = 1'b1;
                w_cmd.addr_inc = 1'b1;
                if (i_sts.s_last) begin
                    w_cmd.addr_clr = 1'b1;
                    n_state        = i_sts.short_set ? S_DTAIL : S_DSCAN;
                end
            end
            S_DSCAN: begin
                w_cmd.dscan    = 1'b1;
                w_cmd.addr_inc = 1'b1;
                if (i_sts.s_last) begin
                    w_cmd.addr_clr = 1'b1;
                    n_state        = S_DTAIL;
                end
            end
            S_DTAIL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

endmodule

`default_nettype wire

[sv/vdpd_datapath.sv]
`default_nettype none

module vdpd_datapath #(
    parameter int MAX_SAMPLES = 256,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire vdpd_pkg::t_cmd                    i_cmd,
    output vdpd_pkg::t_sts                         o_sts,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [vdpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_cfg_wdata,
    input  wire logic                              i_in_valid,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port1_voltage,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port2_voltage,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port3_voltage,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port4_voltage,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_pattern_found,
    output logic [vdpd_pkg::FIELD_W-1:0]           o_plateau_level,
    output logic [vdpd_pkg::FIELD_W-1:0]           o_mode_voltage,
    output logic                                   o_too_short
);
    import vdpd_pkg::*;

    localparam int SW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int HW = SAMPLE_BITS;
    localparam int HD = 1 << HW;
    localparam int AW = (SW > HW) ? SW : HW;
    localparam int DW = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;

    // configuration
    logic [PSEL_W-1:0]  r_psel;
    logic [FIELD_W-1:0] r_tol;
    logic [FIELD_W-1:0] r_depth;

    // memories
    logic [HW-1:0] r_store [MAX_SAMPLES];
    logic [CW-1:0] r_hist  [HD];

    // load path
    logic [FIELD_W-1:0] w_port;
    logic [HW-1:0]      w_v;
    logic               w_load;
    logic [CW-1:0]      r_cnt;
    logic               r_p_vld;
    logic [HW-1:0]      r_p_addr;
    logic               r_lw_vld;
    logic [HW-1:0]      r_lw_addr;
    logic [CW-1:0]      r_lw_data;
    logic [CW-1:0]      w_hbase;
    logic [CW-1:0]      w_hinc;
    logic               w_hwe;
    logic [HW-1:0]      w_hwaddr;
    logic [CW-1:0]      w_hwdata;
    logic [HW-1:0]      w_hraddr;
    logic [CW-1:0]      r_hrd;

    // scan path
    logic [AW-1:0]      r_addr;
    logic               r_htag;
    logic [HW-1:0]      r_hidx;
    logic [CW-1:0]      r_best;
    logic [HW-1:0]      r_mode;
    logic [HW-1:0]      r_srd;
    logic               r_ptag;
    logic               r_dtag;
    logic [SW-1:0]      r_sidx;
    logic               r_pfnd;
    logic [HW-1:0]      r_pmin;
    logic               w_pq;
    logic [HW-1:0]      w_plat;
    logic [HW-1:0]      r_w0;
    logic [HW-1:0]      r_w1;
    logic               r_hb;
    logic               r_pend;
    logic               r_found;
    logic               w_cand;
    logic               w_hi;
    logic               w_short;

    // result register
    logic               r_ovld;
    logic               r_ofound;
    logic [FIELD_W-1:0] r_oplat;
    logic [FIELD_W-1:0] r_omode;
    logic               r_oshort;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psel  <= RST_PORT_SELECT;
            r_tol   <= RST_PLATEAU_TOL;
            r_depth <= RST_DIP_DEPTH;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PORT_SELECT: r_psel  <= i_cfg_wdata[PSEL_W-1:0];
                CFG_PLATEAU_TOL: r_tol   <= i_cfg_wdata;
                CFG_DIP_DEPTH:   r_depth <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // out-of-range selector falls back to port one
    always_comb begin
        case (r_psel)
            PSEL_PORT2: w_port = i_port2_voltage;
            PSEL_PORT3: w_port = i_port3_voltage;
            PSEL_PORT4: w_port = i_port4_voltage;
            default:    w_port = i_port1_voltage;
        endcase
    end

    assign w_v    = HW'(w_port);
    assign w_load = i_cmd.in_rdy && i_in_valid && (r_cnt < CW'(MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_store[r_cnt[SW-1:0]] <= w_v;
        end
        if (i_cmd.pscan || i_cmd.dscan) begin
            r_srd <= r_store[r_addr[SW-1:0]];
        end
    end

    // histogram increment with forwarding of the previous cycle's write
    assign w_hbase  = (r_lw_vld && (r_lw_addr == r_p_addr)) ? r_lw_data : r_hrd;
    assign w_hinc   = w_hbase + CW'(1);
    assign w_hwe    = r_p_vld || i_cmd.hzero;
    assign w_hwaddr = i_cmd.hzero ? r_addr[HW-1:0] : r_p_addr;
    assign w_hwdata = i_cmd.hzero ? '0 : w_hinc;
    assign w_hraddr = i_cmd.hscan ? r_addr[HW-1:0] : w_v;

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_hist[w_hwaddr] <= w_hwdata;
        end
        r_hrd <= r_hist[w_hraddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_lw_vld <= 1'b0;
            r_htag   <= 1'b0;
            r_ptag   <= 1'b0;
            r_dtag   <= 1'b0;
            r_addr   <= '0;
            r_cnt    <= '0;
        end else begin
            r_p_vld  <= w_load;
            r_lw_vld <= r_p_vld;
            r_htag   <= i_cmd.hscan;
            r_ptag   <= i_cmd.pscan;
            r_dtag   <= i_cmd.dscan;
            if (i_cmd.addr_clr) begin
                r_addr <= '0;
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_cnt <= '0;
            end else if (w_load) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_addr  <= w_v;
        r_lw_addr <= r_p_addr;
        r_lw_data <= w_hinc;
        r_hidx    <= r_addr[HW-1:0];
        r_sidx    <= r_addr[SW-1:0];
    end

    // mode: strictly larger count wins, so ties keep the smaller value
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best <= '0;
            r_mode <= '0;
        end else if (r_htag && (r_hrd > r_best)) begin
            r_best <= r_hrd;
            r_mode <= r_hidx;
        end
    end

    // plateau: smallest loaded value within tolerance below the mode
    assign w_pq = (r_srd < r_mode) && (DW'(r_mode - r_srd) <= DW'(r_tol))
                  && (!r_pfnd || (r_srd < r_pmin));
    assign w_plat = r_pfnd ? r_pmin : r_mode;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_pfnd <= 1'b0;
        end else if (r_ptag && w_pq) begin
            r_pfnd <= 1'b1;
            r_pmin <= r_srd;
        end
    end

    // dip scan over a three-sample window, centre is r_w1
    assign w_hi   = r_srd >= w_plat;
    assign w_cand = r_dtag && (r_sidx >= SW'(2)) && r_hb && (r_w1 < r_w0) && (r_w1 < r_srd)
                    && (r_w1 <= w_plat) && (DW'(w_plat - r_w1) >= DW'(r_depth));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_hb    <= 1'b0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else if (r_dtag) begin
            if (w_hi && (r_pend || w_cand)) begin
                r_found <= 1'b1;
            end
            if (w_cand) begin
                r_pend <= 1'b1;
            end
            if ((r_sidx != '0) && (r_w1 >= w_plat)) begin
                r_hb <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dtag) begin
            r_w0 <= r_w1;
            r_w1 <= r_srd;
        end
    end

    assign w_short = r_cnt < CW'(MIN_SET_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ofound <= r_found;
            r_oplat  <= FIELD_W'(w_plat);
            r_omode  <= FIELD_W'(r_mode);
            r_oshort <= w_short;
        end
    end

    assign o_sts.h_last    = (r_addr[HW-1:0] == {HW{1'b1}});
    assign o_sts.s_last    = (r_addr[SW-1:0] == SW'(r_cnt - CW'(1)));
    assign o_sts.short_set = w_short;
    assign o_sts.out_free  = !r_ovld || i_out_ready;

    assign o_out_valid     = r_ovld;
    assign o_pattern_found = r_ofound;
    assign o_plateau_level = r_oplat;
    assign o_mode_voltage  = r_omode;
    assign o_too_short     = r_oshort;

endmodule

`default_nettype wire

[sv/voltage_dip_pattern_detector_unit.sv]
// Voltage dip pattern detector. Samples of the selected port are taken one per
// clock on the input channel; the request with last_sample high closes the set
// and starts the analysis, after which one result request carries the mode, the
// plateau level, the match flag and the too-short flag. After a set of N stored
// samples (at most MAX_SAMPLES, extra samples are dropped) the input stays
// not-ready during the analysis: a drain state finishes the last histogram
// update, the histogram memory is swept once (reading and clearing each
// counter), and the sample store is read once for the plateau and, unless the
// set holds under six samples, once more for the dip. The result waits in an
// output register, so the next set may load while it is pending; if that set
// finishes first, its final cycle is held (input still not-ready) until the
// pending result is taken. After reset every histogram counter is cleared
// before the first sample is taken; configuration writes are taken at
// any time.
`default_nettype none

module voltage_dip_pattern_detector_unit #(
    parameter int MAX_SAMPLES = 256,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [vdpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port1_voltage,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port2_voltage,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port3_voltage,
    input  wire logic [vdpd_pkg::FIELD_W-1:0]      i_port4_voltage,
    input  wire logic                              i_last_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_pattern_found,
    output logic [vdpd_pkg::FIELD_W-1:0]           o_plateau_level,
    output logic [vdpd_pkg::FIELD_W-1:0]           o_mode_voltage,
    output logic                                   o_too_short
);
    import vdpd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    vdpd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    vdpd_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_port1_voltage (i_port1_voltage),
        .i_port2_voltage (i_port2_voltage),
        .i_port3_voltage (i_port3_voltage),
        .i_port4_voltage (i_port4_voltage),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_pattern_found (o_pattern_found),
        .o_plateau_level (o_plateau_level),
        .o_mode_voltage  (o_mode_voltage),
        .o_too_short     (o_too_short)
    );

    assign o_in_ready = w_cmd.in_rdy;

endmodule

`default_nettype wire

[sv/vdpd_checker.sv]
`default_nettype none
`include "voltage_dip_pattern_detector_unit_defines.svh"

module vdpd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_pattern_found,
    input wire logic o_too_short
);

    // a stalled result stays offered
    `VDPD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // a short set never reports a match
    `VDPD_ASSERT(a_short_no_match, i_clk, i_rst_n, o_out_valid |-> !(o_too_short && o_pattern_found), "match flagged on a short set")

    // a new result only appears after the input side was busy analysing
    `VDPD_ASSERT(a_result_after_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> !$past(o_in_ready), "result appeared while loading")

    // histogram clearing holds off input right after reset
    `VDPD_ASSERT_NR(a_rst_busy, i_clk, !i_rst_n |=> !o_in_ready, "input ready during clearing pass")

endmodule

bind voltage_dip_pattern_detector_unit vdpd_checker u_vdpd_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;

    import vdpd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int STORE_DEPTH = 256;
    localparam int HIST_BINS   = 1024;
    localparam int HOLD_CYCLES = 5000;
    localparam int TAIL_CYCLES = 1600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PORTS_W     = 4 * FIELD_W;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] plateau;
        logic [FIELD_W-1:0] mode;
        logic               too_short;
    } t_dip_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FIELD_W-1:0]   i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [FIELD_W-1:0]   i_port1_voltage = '0;
    logic [FIELD_W-1:0]   i_port2_voltage = '0;
    logic [FIELD_W-1:0]   i_port3_voltage = '0;
    logic [FIELD_W-1:0]   i_port4_voltage = '0;
    logic                 i_last_sample = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_pattern_found;
    logic [FIELD_W-1:0]   o_plateau_level;
    logic [FIELD_W-1:0]   o_mode_voltage;
    logic                 o_too_short;

    voltage_dip_pattern_detector_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_port1_voltage (i_port1_voltage),
        .i_port2_voltage (i_port2_voltage),
        .i_port3_voltage (i_port3_voltage),
        .i_port4_voltage (i_port4_voltage),
        .i_last_sample   (i_last_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pattern_found (o_pattern_found),
        .o_plateau_level (o_plateau_level),
        .o_mode_voltage  (o_mode_voltage),
        .o_too_short     (o_too_short)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [PSEL_W-1:0]  port_sel = RST_PORT_SELECT;
    logic [FIELD_W-1:0] plat_tol = RST_PLATEAU_TOL;
    logic [FIELD_W-1:0] min_depth = RST_DIP_DEPTH;
    logic [FIELD_W-1:0] set_volts[$];
    int                 volt_hist[HIST_BINS];
    t_dip_report        expected_reports[$];
    int                 directed_volts[$];

    int fail_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic int port_index(logic [PSEL_W-1:0] sel);
        case (sel)
            PSEL_PORT2: return 1;
            PSEL_PORT3: return 2;
            PSEL_PORT4: return 3;
            default:    return 0;
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] clip10(int x);
        if (x < 0) return '0;
        if (x > HIST_BINS - 1) return '1;
        return x[FIELD_W-1:0];
    endfunction

    function automatic logic dip_between_plateaus(int plateau);
        int  n = set_volts.size();
        int  last_high = 0;
        bit  any_high = 0;
        bit  high_before;
        int  v;
        if (n < 3) return 1'b0;
        for (int k = 0; k < n; k++) begin
            if (int'(set_volts[k]) >= plateau) begin
                last_high = k;
                any_high = 1;
            end
        end
        if (!any_high) return 1'b0;
        high_before = int'(set_volts[0]) >= plateau;
        for (int k = 1; k + 1 < n; k++) begin
            v = int'(set_volts[k]);
            if (high_before && last_high > k && v < int'(set_volts[k-1]) &&
                v < int'(set_volts[k+1]) && v <= plateau &&
                plateau - v >= int'(min_depth))
                return 1'b1;
            if (v >= plateau) high_before = 1;
        end
        return 1'b0;
    endfunction

    function automatic t_dip_report judge_set();
        t_dip_report r;
        int best = 0;
        int mode = 0;
        int plateau;
        for (int k = 0; k < HIST_BINS; k++) begin
            if (volt_hist[k] > best) begin
                best = volt_hist[k];
                mode = k;
            end
        end
        plateau = mode;
        for (int k = 0; k < mode; k++) begin
            if (volt_hist[k] != 0 && mode - k <= int'(plat_tol)) begin
                plateau = k;
                break;
            end
        end
        r.too_short = set_volts.size() < MIN_SET_LEN;
        r.found     = r.too_short ? 1'b0 : dip_between_plateaus(plateau);
        r.plateau   = plateau[FIELD_W-1:0];
        r.mode      = mode[FIELD_W-1:0];
        return r;
    endfunction

    task automatic track_sample(logic [3:0][FIELD_W-1:0] volts, logic is_last);
        logic [FIELD_W-1:0] v;
        v = volts[port_index(port_sel)];
        // samples past the store depth are dropped, the closing one too
        if (set_volts.size() < STORE_DEPTH) begin
            set_volts.push_back(v);
            volt_hist[v]++;
        end
        if (is_last) begin
            expected_reports.push_back(judge_set());
            set_volts.delete();
            foreach (volt_hist[k]) volt_hist[k] = 0;
        end
    endtask

    task automatic send_sample(logic [3:0][FIELD_W-1:0] volts, logic is_last);
        int gap = 0;
        bit taken;
        while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_port1_voltage <= volts[0];
        i_port2_voltage <= volts[1];
        i_port3_voltage <= volts[2];
        i_port4_voltage <= volts[3];
        i_last_sample   <= is_last;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        track_sample(volts, is_last);
    endtask

    task automatic send_values();
        logic [3:0][FIELD_W-1:0] volts;
        for (int i = 0; i < directed_volts.size(); i++) begin
            volts = PORTS_W'({$urandom, $urandom});
            volts[port_index(port_sel)] = clip10(directed_volts[i]);
            send_sample(volts, i == directed_volts.size() - 1);
        end
    endtask

    task automatic send_shaped_set(int len, bit noisy);
        logic [3:0][FIELD_W-1:0] volts;
        int base;
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 10) base = HIST_BINS - 1;
        else if (r < 20) base = 0;
        else base = $urandom_range(HIST_BINS - 1);
        for (int i = 0; i < len; i++) begin
            volts = PORTS_W'({$urandom, $urandom});
            r = $urandom_range(99);
            if (noisy || r >= 92) v = $urandom_range(HIST_BINS - 1);
            else if (r < 50) v = base;
            else if (r < 70) v = base - int'($urandom_range(int'(plat_tol) + 2));
            else if (r < 85) v = base - int'($urandom_range(int'(min_depth) + 4));
            else v = base + int'($urandom_range(20));
            volts[port_index(port_sel)] = clip10(v);
            send_sample(volts, i == len - 1);
        end
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_PORT_SELECT: port_sel = data[PSEL_W-1:0];
            CFG_PLATEAU_TOL: plat_tol = data;
            CFG_DIP_DEPTH:   min_depth = data;
            default: ;
        endcase
    endtask

    function automatic logic [FIELD_W-1:0] pick_level();
        int r = $urandom_range(99);
        if (r < 20) return '0;
        if (r < 30) return '1;
        if (r < 80) return FIELD_W'($urandom_range(60));
        return FIELD_W'($urandom_range(HIST_BINS - 1));
    endfunction

    task automatic reprogram(logic [FIELD_W-1:0] tol, logic [FIELD_W-1:0] depth);
        logic [FIELD_W-1:0] sel_word;
        drain_reports();
        sel_word = FIELD_W'($urandom);
        sel_word[PSEL_W-1:0] = PSEL_W'($urandom_range(7));
        write_reg(CFG_PORT_SELECT, sel_word);
        write_reg(CFG_PLATEAU_TOL, tol);
        write_reg(CFG_DIP_DEPTH, depth);
    endtask

    // reset values: shallow candidate before a real dip, extremes, short set
    task automatic test_reset_config_sets();
        directed_volts = '{500, 500, 480, 500, 400, 500, 500, 500};
        send_values();
        directed_volts = '{1023, 1023, 0, 1023, 1023, 1023};
        send_values();
        directed_volts = '{700, 690, 600, 700, 700};
        send_values();
    endtask

    // every selector code, out-of-range codes fall back to port one
    task automatic test_port_select();
        logic [FIELD_W-1:0] sel_word;
        for (int s = 0; s < 8; s++) begin
            drain_reports();
            sel_word = FIELD_W'($urandom);
            sel_word[PSEL_W-1:0] = PSEL_W'(s);
            write_reg(CFG_PORT_SELECT, sel_word);
            send_sample(PORTS_W'({$urandom, $urandom}), 1'b1);
        end
    endtask

    task automatic test_spare_index();
        drain_reports();
        write_reg(CFG_SPARE, FIELD_W'($urandom));
        send_shaped_set(7, 1'b0);
    endtask

    task automatic test_overflow_set();
        reprogram(pick_level(), pick_level());
        send_shaped_set(STORE_DEPTH + 2, 1'b0);
    endtask

    task automatic test_output_backpressure();
        drain_reports();
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge i_clk);
        hold_token++;
        @(posedge i_clk);
        repeat (3) send_shaped_set(8, 1'b0);
        drain_reports();
    endtask

    task automatic test_random_traffic(int s_pct, int r_pct, int items,
                                       logic [FIELD_W-1:0] tol, logic [FIELD_W-1:0] depth);
        int sent = 0;
        int sets = 0;
        int len;
        int r;
        sender_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        reprogram(tol, depth);
        while (sent < items) begin
            r = $urandom_range(99);
            if (r < 10) len = $urandom_range(1, MIN_SET_LEN - 1);
            else if (r < 14) len = MIN_SET_LEN;
            else len = $urandom_range(7, 24);
            send_shaped_set(len, $urandom_range(99) < 15);
            sent += len;
            sets++;
            if (sets % 6 == 0) reprogram(pick_level(), pick_level());
        end
        drain_reports();
    endtask

    // result channel ready, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic compare_field(string what, logic [FIELD_W-1:0] want,
                                 logic [FIELD_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // result request is taken at the next rising edge
    always @(negedge i_clk) begin : check_reports
        t_dip_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                fail_count++;
                $display("%0t unexpected report expected none actual %b %0d %0d %b", $time,
                         o_pattern_found, o_plateau_level, o_mode_voltage, o_too_short);
            end else begin
                want = expected_reports.pop_front();
                compare_field("pattern_found", FIELD_W'(want.found),
                              FIELD_W'(o_pattern_found));
                compare_field("plateau_level", want.plateau, o_plateau_level);
                compare_field("mode_voltage", want.mode, o_mode_voltage);
                compare_field("too_short", FIELD_W'(want.too_short),
                              FIELD_W'(o_too_short));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("voltage_dip_pattern_detector_unit: mismatch");
            $finish;
        end
    end

    initial begin
        foreach (volt_hist[k]) volt_hist[k] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config_sets();
        test_port_select();
        test_spare_index();
        test_overflow_set();
        test_output_backpressure();
        test_random_traffic(15, 85, 220, '0, '0);
        test_random_traffic(85, 15, 220, '1, '1);
        test_random_traffic(0, 0, 220, pick_level(), pick_level());
        drain_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("voltage_dip_pattern_detector_unit: match");
        end else begin
            $display("voltage_dip_pattern_detector_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
